### rtl/core/first_fit_chunk_allocator_unit_defines.svh
// ----------------------------------------------------------------------------
// First-fit chunk allocator assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off while in reset.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_CHUNK_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_CHUNK_ALLOCATOR_UNIT_DEFINES_SVH

// Property that must hold at every clock edge out of reset
`define FFCA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next cycle
`define FFCA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

### rtl/core/ffca_pkg.sv
// ----------------------------------------------------------------------------
// First-fit chunk allocator package
// Sizes, operation and status codes, and the scan unit interface types.
// ----------------------------------------------------------------------------
package ffca_pkg;

  // Table geometry
  localparam int MAX_CHUNKS = 64;
  localparam int SIZE_BITS  = 16;
  localparam int IDX_W      = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int CNT_W      = $clog2(MAX_CHUNKS + 1);

  // Fixed field widths
  localparam int AMT_W      = 16;
  localparam int OUT_IDX_W  = 6;
  localparam int STATUS_W   = 3;
  localparam int CAP_W      = 16;
  localparam int SUM_W      = AMT_W + 1;
  localparam int CMP_W      = (SIZE_BITS > AMT_W) ? SIZE_BITS : AMT_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);
  localparam logic [AMT_W-1:0] GRANT_MAX = '1;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_REQUEST = 1'b1
  } ffca_op_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_LOADED  = 3'd0,
    STAT_GRANTED = 3'd1,
    STAT_NO_FIT  = 3'd2,
    STAT_CAP_HIT = 3'd3,
    STAT_IGNORED = 3'd4,
    STAT_FULL    = 3'd5
  } ffca_status_e;

  // Command from the control sequencer to the scan unit
  typedef struct packed {
    logic                 load;
    logic                 start;
    logic [SIZE_BITS-1:0] wr_size;
    logic [AMT_W-1:0]     amount;
  } ffca_cmd_t;

  // Scan completion, a one-cycle pulse on done
  typedef struct packed {
    logic                 done;
    logic                 hit;
    logic [IDX_W-1:0]     idx;
    logic [SIZE_BITS-1:0] size;
  } ffca_rsp_t;

endpackage

### rtl/core/ffca_scan_unit.sv
// ----------------------------------------------------------------------------
// First-fit chunk allocator scan unit
// Holds the chunk size memory and free marks, appends loaded chunks and walks
// the table one entry per cycle through a single shared size comparator.
// ----------------------------------------------------------------------------
`include "first_fit_chunk_allocator_unit_defines.svh"

module ffca_scan_unit
  import ffca_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ffca_cmd_t        cmd_i,
  output ffca_rsp_t        rsp_o,
  output logic [CNT_W-1:0] count_o
);

  typedef enum logic {
    SC_IDLE,
    SC_RUN
  } sc_state_e;

  sc_state_e             sc_state_q;
  logic [CNT_W-1:0]      count_q;
  logic [CNT_W-1:0]      ptr_q;
  logic                  cmp_vld_q;
  logic [IDX_W-1:0]      cmp_idx_q;
  logic [MAX_CHUNKS-1:0] free_q;
  ffca_rsp_t             rsp_q;

  logic [SIZE_BITS-1:0]  mem [MAX_CHUNKS];
  logic [SIZE_BITS-1:0]  rd_data_q;

  logic                  fits;
  logic                  hit;
  logic                  last;

  // Chunk memory: append port and one registered scan read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mem[count_q[IDX_W-1:0]] <= cmd_i.wr_size;
    end
    if (ptr_q < count_q) begin
      rd_data_q <= mem[ptr_q[IDX_W-1:0]];
    end
  end

  // Shared comparator on the entry read last cycle
  assign fits = CMP_W'(rd_data_q) >= CMP_W'(cmd_i.amount);
  assign hit  = cmp_vld_q && free_q[cmp_idx_q] && fits;
  assign last = cmp_vld_q && ((CNT_W'(cmp_idx_q) + CNT_W'(1)) == count_q);

  // Scan sequencer, free marks and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_state_q <= SC_IDLE;
      count_q    <= '0;
      ptr_q      <= '0;
      cmp_vld_q  <= 1'b0;
      cmp_idx_q  <= '0;
      free_q     <= '0;
      rsp_q      <= '0;
    end else begin
      rsp_q.done <= 1'b0;
      if (cmd_i.load) begin
        free_q[count_q[IDX_W-1:0]] <= 1'b1;
        count_q                    <= count_q + CNT_W'(1);
      end
      unique case (sc_state_q)
        SC_IDLE: begin
          cmp_vld_q <= 1'b0;
          ptr_q     <= '0;
          if (cmd_i.start) begin
            if (count_q == '0) begin
              // empty table: miss at once
              rsp_q.done <= 1'b1;
              rsp_q.hit  <= 1'b0;
            end else begin
              sc_state_q <= SC_RUN;
            end
          end
        end
        SC_RUN: begin
          cmp_vld_q <= ptr_q < count_q;
          cmp_idx_q <= ptr_q[IDX_W-1:0];
          if (ptr_q < count_q) begin
            ptr_q <= ptr_q + CNT_W'(1);
          end
          if (hit) begin
            free_q[cmp_idx_q] <= 1'b0;
            rsp_q.done        <= 1'b1;
            rsp_q.hit         <= 1'b1;
            rsp_q.idx         <= cmp_idx_q;
            rsp_q.size        <= rd_data_q;
            cmp_vld_q         <= 1'b0;
            sc_state_q        <= SC_IDLE;
          end else if (last) begin
            rsp_q.done <= 1'b1;
            rsp_q.hit  <= 1'b0;
            cmp_vld_q  <= 1'b0;
            sc_state_q <= SC_IDLE;
          end
        end
        default: sc_state_q <= SC_IDLE;
      endcase
    end
  end

  assign rsp_o   = rsp_q;
  assign count_o = count_q;

  // Checks
  `FFCA_ASSERT(a_count_bound, count_q <= CNT_W'(MAX_CHUNKS), "chunk count beyond table")
  `FFCA_ASSERT(a_cmd_excl, !(cmd_i.load && cmd_i.start), "load and scan start together")
  `FFCA_ASSERT(a_hit_clears, (rsp_q.done && rsp_q.hit) |-> !free_q[rsp_q.idx],
               "granted chunk still marked free")
  `FFCA_ASSERT(a_scan_in_table, cmp_vld_q |-> (CNT_W'(cmp_idx_q) < count_q),
               "compare on entry beyond fill count")

endmodule

### rtl/core/first_fit_chunk_allocator_unit.sv
// ----------------------------------------------------------------------------
// First-fit chunk allocator unit
// Appends chunk sizes to a table and grants requests from the lowest-index
// free chunk large enough, under a cap on the total granted size.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake                 Payload
//  in       in   in_valid_i / in_stall_o   op_i, amount_i
//  out      out  out_valid_o / out_stall_i status_o, chunk_index_o, chunk_size_o,
//                                          total_allocated_o, successes_o
//  cfg      in   cfg_we_i                  cfg_data_i (allocation cap)
//
// Loads, ignored and refused items go from accept straight to the finish state, with no scan.
// A request scans the table one entry per cycle through one comparator and
// ends at the first free entry that fits, a grant, or after the last entry,
// a miss; on an empty table it misses at once.
// One transaction is worked on at a time; in_stall_o is high while busy.
// A finished result waits in the output register while out_stall_i is high.
// Reset clears the table marks, fill count, totals and halt; the cap is 1024.
// ----------------------------------------------------------------------------
`include "first_fit_chunk_allocator_unit_defines.svh"

module first_fit_chunk_allocator_unit
  import ffca_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [CAP_W-1:0]     cfg_data_i,
  // input transactions
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 op_i,
  input  logic [AMT_W-1:0]     amount_i,
  // result transactions
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [STATUS_W-1:0]  status_o,
  output logic [OUT_IDX_W-1:0] chunk_index_o,
  output logic [AMT_W-1:0]     chunk_size_o,
  output logic [AMT_W-1:0]     total_allocated_o,
  output logic [AMT_W-1:0]     successes_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  state_e               state_q;
  logic [CAP_W-1:0]     cap_q;
  logic                 halted_q;
  logic [AMT_W-1:0]     sum_q;
  logic [AMT_W-1:0]     grant_q;
  logic [AMT_W-1:0]     amt_q;

  ffca_status_e         res_status_q;
  logic [OUT_IDX_W-1:0] res_idx_q;
  logic [AMT_W-1:0]     res_size_q;

  logic                 out_valid_q;
  ffca_status_e         status_q;
  logic [OUT_IDX_W-1:0] index_q;
  logic [AMT_W-1:0]     size_q;
  logic [AMT_W-1:0]     total_q;
  logic [AMT_W-1:0]     succ_q;

  logic                 accept;
  logic                 is_load;
  logic                 full;
  logic                 cap_exceed;
  logic                 out_free;
  logic [CNT_W-1:0]     count;
  ffca_cmd_t            cmd;
  ffca_rsp_t            rsp;

  // Handshake and decode
  assign in_stall_o = state_q != ST_IDLE;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_load    = op_i == OP_LOAD;
  assign full       = count == CNT_W'(MAX_CHUNKS);
  assign cap_exceed = ({1'b0, sum_q} + {1'b0, amount_i}) > SUM_W'(cap_q);
  assign out_free   = !out_valid_q || !out_stall_i;

  // Commands to the scan unit
  always_comb begin
    cmd.load    = accept && is_load && !full;
    cmd.start   = accept && !is_load && !halted_q && !cap_exceed;
    cmd.wr_size = SIZE_BITS'(amount_i);
    cmd.amount  = amt_q;
  end

  ffca_scan_unit u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .rsp_o   (rsp),
    .count_o (count)
  );

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_data_i;
    end
  end

  // Control sequencer, running totals and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      halted_q     <= 1'b0;
      sum_q        <= '0;
      grant_q      <= '0;
      amt_q        <= '0;
      res_status_q <= STAT_LOADED;
      res_idx_q    <= '0;
      res_size_q   <= '0;
      out_valid_q  <= 1'b0;
      status_q     <= STAT_LOADED;
      index_q      <= '0;
      size_q       <= '0;
      total_q      <= '0;
      succ_q       <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            amt_q      <= amount_i;
            res_idx_q  <= '0;
            res_size_q <= '0;
            state_q    <= ST_FINISH;
            if (is_load) begin
              if (full) begin
                res_status_q <= STAT_FULL;
              end else begin
                res_status_q <= STAT_LOADED;
                res_idx_q    <= OUT_IDX_W'(count);
              end
            end else if (halted_q) begin
              res_status_q <= STAT_IGNORED;
            end else if (cap_exceed) begin
              halted_q     <= 1'b1;
              res_status_q <= STAT_CAP_HIT;
            end else begin
              state_q <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (rsp.done) begin
            state_q <= ST_FINISH;
            if (rsp.hit) begin
              res_status_q <= STAT_GRANTED;
              res_idx_q    <= OUT_IDX_W'(rsp.idx);
              res_size_q   <= AMT_W'(rsp.size);
              sum_q        <= sum_q + amt_q;
              if (grant_q != GRANT_MAX) begin
                grant_q <= grant_q + AMT_W'(1);
              end
            end else begin
              res_status_q <= STAT_NO_FIT;
            end
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            status_q    <= res_status_q;
            index_q     <= res_idx_q;
            size_q      <= res_size_q;
            total_q     <= sum_q;
            succ_q      <= grant_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign chunk_index_o     = index_q;
  assign chunk_size_o      = size_q;
  assign total_allocated_o = total_q;
  assign successes_o       = succ_q;

  // Checks
  `FFCA_ASSERT(a_done_in_scan, rsp.done |-> (state_q == ST_SCAN), "scan done while not scanning")
  `FFCA_ASSERT_NEXT(a_halt_sticks, halted_q, halted_q, "halt flag cleared")
  `FFCA_ASSERT(a_result_from_finish, $rose(out_valid_q) |-> $past(state_q == ST_FINISH),
               "result shown without finishing a transaction")
  `FFCA_ASSERT(a_out_hold, (out_valid_q && out_stall_i && state_q == ST_FINISH)
               |=> (out_valid_q && $stable(status_q)), "pending result overwritten")

endmodule
